FILE: hdl/bbr_pkg.sv
// Package for the bitstream bit reader: window geometry, command and status codes,
// and the request/result structs shared between the stages. No dependencies.
package bbr_pkg;

    // Stream word size held in each window slot
    localparam int WORD_BITS = 32;
    // Width of the head fill counter (0..WORD_BITS)
    localparam int HBL_W     = $clog2(WORD_BITS + 1);
    // Two-word window and the counter width that covers its full fill (0..2*WORD_BITS)
    localparam int WIN_W     = 2 * WORD_BITS;
    localparam int CNT_W     = $clog2(WIN_W + 1);

    // Command codes
    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_SHOW  = 3'd1;
    localparam logic [2:0] CMD_GET   = 3'd2;
    localparam logic [2:0] CMD_FLUSH = 3'd3;
    localparam logic [2:0] CMD_ALIGN = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Largest bit count served per request
    localparam logic [5:0] MAX_COUNT = 6'd32;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  bit_count;
        logic [31:0] stream_word;
    } request_t;

    typedef struct packed {
        logic [31:0] field_value;
        logic [1:0]  status;
        logic [6:0]  bits_buffered;
        logic        want_word;
    } result_t;

endpackage

FILE: hdl/bbr_in_reg.sv
// Input register stage of the bit reader: captures one request per cycle while it has room (s_ready).
// Depends on bbr_pkg for the request struct.
module bbr_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  bbr_pkg::request_t s_req,
    output logic              s_ready,
    input  logic              advance,
    output logic              req_valid,
    output bbr_pkg::request_t req
);

    logic              valid_reg;
    bbr_pkg::request_t req_reg;

    // Free when empty or when the held request moves on this cycle
    assign s_ready   = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg <= s_req;
        end
    end

endmodule

FILE: hdl/bbr_window.sv
// Two-word bit window: head/tail word state and the single-pass command datapath.
// Depends on bbr_pkg for geometry, codes and structs.
module bbr_window (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  bbr_pkg::request_t req,
    output bbr_pkg::result_t  res
);

    logic [bbr_pkg::WORD_BITS-1:0] head_reg, head_next;
    logic [bbr_pkg::WORD_BITS-1:0] tail_reg, tail_next;
    logic [bbr_pkg::HBL_W-1:0]     hbl_reg, hbl_next;
    logic                          tv_reg, tv_next;

    logic [5:0]                    n_sat;
    logic [bbr_pkg::CNT_W-1:0]     n_c, hbl_c, buf_c, sh, rem, cnt_next;
    logic [bbr_pkg::WIN_W-1:0]     shifted;
    logic [bbr_pkg::WIN_W+31:0]    shifted_ext;
    logic [32:0]                   mask;
    logic [31:0]                   peek;
    logic [bbr_pkg::WORD_BITS+31:0] word_ext;
    logic [bbr_pkg::WORD_BITS-1:0] word;
    logic [bbr_pkg::HBL_W-1:0]     aligned;
    logic [bbr_pkg::CNT_W+7:0]     cnt_wide;
    logic [31:0]                   value;
    logic [1:0]                    status;

    // Operand prep: saturated count, fill levels, loaded word fit to slot width
    always_comb begin
        n_sat    = (req.bit_count > bbr_pkg::MAX_COUNT) ? bbr_pkg::MAX_COUNT : req.bit_count;
        n_c      = bbr_pkg::CNT_W'(n_sat);
        hbl_c    = bbr_pkg::CNT_W'(hbl_reg);
        buf_c    = hbl_c + (tv_reg ? bbr_pkg::CNT_W'(bbr_pkg::WORD_BITS)
                                   : {bbr_pkg::CNT_W{1'b0}});
        word_ext = {{bbr_pkg::WORD_BITS{1'b0}}, req.stream_word};
        word     = word_ext[bbr_pkg::WORD_BITS-1:0];
        aligned  = hbl_reg & ~bbr_pkg::HBL_W'(7);
        rem      = n_c - hbl_c;
    end

    // Bit extraction: read position sits at bit WORD_BITS+hbl-1 of {head, tail}
    always_comb begin
        sh          = bbr_pkg::CNT_W'(bbr_pkg::WORD_BITS) + hbl_c - n_c;
        shifted     = {head_reg, tail_reg} >> sh;
        shifted_ext = {32'd0, shifted};
        mask        = (33'd1 << n_sat) - 33'd1;
        peek        = shifted_ext[31:0] & mask[31:0];
    end

    // Command decode and next state
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        hbl_next  = hbl_reg;
        tv_next   = tv_reg;
        value     = 32'd0;
        status    = bbr_pkg::STATUS_OK;
        unique case (req.cmd) inside
            bbr_pkg::CMD_LOAD: begin
                if (hbl_reg == '0 && !tv_reg) begin
                    head_next = word;
                    hbl_next  = bbr_pkg::HBL_W'(bbr_pkg::WORD_BITS);
                end else if (!tv_reg) begin
                    tail_next = word;
                    tv_next   = 1'b1;
                end else begin
                    status = bbr_pkg::STATUS_FULL;
                end
            end
            bbr_pkg::CMD_SHOW, bbr_pkg::CMD_GET, bbr_pkg::CMD_FLUSH: begin
                if (n_c > buf_c) begin
                    status = bbr_pkg::STATUS_SHORT;
                end else begin
                    if (req.cmd != bbr_pkg::CMD_FLUSH) begin
                        value = peek;
                    end
                    if (req.cmd != bbr_pkg::CMD_SHOW) begin
                        // Consume: stay in head, or spill into the tail word
                        if (n_c < hbl_c) begin
                            hbl_next = bbr_pkg::HBL_W'(hbl_c - n_c);
                        end else if (tv_reg) begin
                            head_next = tail_reg;
                            tail_next = '0;
                            tv_next   = 1'b0;
                            hbl_next  = bbr_pkg::HBL_W'(
                                bbr_pkg::CNT_W'(bbr_pkg::WORD_BITS) - rem);
                        end else begin
                            hbl_next = '0;
                        end
                    end
                end
            end
            bbr_pkg::CMD_ALIGN: begin
                // Drop to the byte boundary; an emptied head takes the tail
                if (aligned == '0 && tv_reg) begin
                    head_next = tail_reg;
                    tail_next = '0;
                    tv_next   = 1'b0;
                    hbl_next  = bbr_pkg::HBL_W'(bbr_pkg::WORD_BITS);
                end else begin
                    hbl_next = aligned;
                end
            end
            default: begin
            end
        endcase
    end

    // Result fields from the post-request state
    always_comb begin
        cnt_next = bbr_pkg::CNT_W'(hbl_next) +
                   (tv_next ? bbr_pkg::CNT_W'(bbr_pkg::WORD_BITS) : {bbr_pkg::CNT_W{1'b0}});
        cnt_wide = {8'd0, cnt_next};
        res.field_value   = value;
        res.status        = status;
        res.bits_buffered = (cnt_wide > (bbr_pkg::CNT_W + 8)'(127)) ? 7'd127 : cnt_wide[6:0];
        res.want_word     = !tv_next;
    end

    // Window state, updated when the request moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            hbl_reg  <= '0;
            tv_reg   <= 1'b0;
        end else if (advance) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            hbl_reg  <= hbl_next;
            tv_reg   <= tv_next;
        end
    end

endmodule

FILE: hdl/bbr_out_reg.sv
// Result register stage of the bit reader: holds one result until taken.
// Depends on bbr_pkg for the result struct.
module bbr_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  bbr_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output bbr_pkg::result_t m_res
);

    logic             valid_reg;
    bbr_pkg::result_t res_reg;

    // Room for a new result when empty or when the held one is taken now
    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

endmodule

FILE: hdl/bitstream_bit_reader_core.sv
// Bitstream bit reader: MSB-first load/show/get/flush/align over a two-word window.
// A request passes through the input register and then the result register before its result is valid.
// Throughput: one request per cycle while results are taken; the window state updates in one pass per request.
// Reset (aresetn low, synchronous): window empty, both stages empty.
// Depends on bbr_pkg, bbr_in_reg, bbr_window, bbr_out_reg.
module bitstream_bit_reader_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [5:0]  s_bit_count,
    input  logic [31:0] s_stream_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_field_value,
    output logic [1:0]  m_status,
    output logic [6:0]  m_bits_buffered,
    output logic        m_want_word
);

    bbr_pkg::request_t s_req, req;
    bbr_pkg::result_t  res, m_res;
    logic              req_valid, out_free, advance;

    assign s_req.cmd         = s_cmd;
    assign s_req.bit_count   = s_bit_count;
    assign s_req.stream_word = s_stream_word;

    // A held request is processed when the result register can take it
    assign advance = req_valid && out_free;

    bbr_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_req     (s_req),
        .s_ready   (s_ready),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    bbr_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req),
        .res     (res)
    );

    bbr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_field_value   = m_res.field_value;
    assign m_status        = m_res.status;
    assign m_bits_buffered = m_res.bits_buffered;
    assign m_want_word     = m_res.want_word;

endmodule
